@@ sv/assert_macros.svh @@
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ sv/dccs_pkg.sv @@
// Types and constants of the disk controller command sequencer.
package dccs_pkg;
    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;
    localparam logic [1:0] K_DRIVE = 2'd3;

    localparam logic [2:0] R_DS = 3'd0;
    localparam logic [2:0] R_ER = 3'd1;
    localparam logic [2:0] R_CS = 3'd2;
    localparam logic [2:0] R_WC = 3'd3;
    localparam logic [2:0] R_BA = 3'd4;
    localparam logic [2:0] R_DA = 3'd5;
    localparam logic [2:0] R_DB = 3'd7;

    localparam logic [2:0] FN_RESET  = 3'd0;
    localparam logic [2:0] FN_WRITE  = 3'd1;
    localparam logic [2:0] FN_READ   = 3'd2;
    localparam logic [2:0] FN_WCHECK = 3'd3;
    localparam logic [2:0] FN_SEEK   = 3'd4;
    localparam logic [2:0] FN_RCHECK = 3'd5;
    localparam logic [2:0] FN_DRESET = 3'd6;
    localparam logic [2:0] FN_WLOCK  = 3'd7;

    localparam logic [15:0] CS_GO  = 16'h0001;
    localparam logic [15:0] CS_IDE = 16'h0040;
    localparam logic [15:0] CS_RDY = 16'h0080;
    localparam logic [15:0] CS_SSE = 16'h0100;
    localparam logic [15:0] CS_FMT = 16'h0400;
    localparam logic [15:0] CS_IBA = 16'h0800;
    localparam logic [15:0] CS_SCP = 16'h2000;
    localparam logic [15:0] CS_HE  = 16'h4000;
    localparam logic [15:0] CS_ERR = 16'h8000;
    localparam logic [15:0] CS_WRITABLE = 16'h0f7f;

    localparam logic [15:0] ER_WCE = 16'h0001;
    localparam logic [15:0] ER_NXS = 16'h0020;
    localparam logic [15:0] ER_NXC = 16'h0040;
    localparam logic [15:0] ER_NXD = 16'h0080;
    localparam logic [15:0] ER_NXM = 16'h0400;
    localparam logic [15:0] ER_PGE = 16'h0800;
    localparam logic [15:0] ER_OVR = 16'h4000;
    localparam logic [15:0] ER_DRE = 16'h8000;

    localparam logic [12:0] DS_DRY = 13'h0080;
    localparam logic [12:0] DS_SIN = 13'h0200;
    localparam logic [12:0] DS_DRU = 13'h0400;
    localparam logic [12:0] DS_DPL = 13'h1000;
    localparam logic [12:0] DS_MASK = 13'h1fef;

    localparam logic [1:0] DIR_READ   = 2'd0;
    localparam logic [1:0] DIR_WRITE  = 2'd1;
    localparam logic [1:0] DIR_WCHECK = 2'd2;
    localparam logic [1:0] DIR_HEADER = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reg_index;
        logic [15:0] write_data;
        logic        dma_timeout;
        logic        compare_mismatch;
        logic [15:0] last_word;
        logic [2:0]  drive_unit;
        logic [12:0] drive_status;
        logic        search_complete;
    } t_cmd;

    typedef struct packed {
        logic [15:0] read_data;
        logic        interrupt;
        logic        ready_res;
        logic        sector_request;
        logic [1:0]  transfer_direction;
        logic [15:0] request_disk_address;
        logic [17:0] request_bus_address;
        logic [8:0]  request_word_count;
        logic        seek_start;
        logic        drive_reset_start;
        logic        write_protect_set;
    } t_res;

    // Classified item passed from front to back.
    typedef struct packed {
        t_cmd cmd;
        logic is_go;
        logic is_done;
    } t_item;
endpackage

@@ sv/dccs_if.sv @@
// Valid/ready channel interfaces of the sequencer.
interface dccs_cmd_if import dccs_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dccs_res_if import dccs_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/dccs_front.sv @@
// Front end: accept items, tag them, and queue them for the back end.
module dccs_front import dccs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dccs_cmd_if.sink i_cmd,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_ready
);
    // two-entry queue
    t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    t_item n_item;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push = i_cmd.valid && i_cmd.ready;
    assign pop  = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_mem[r_rp];

    always_comb begin
        n_item.cmd = i_cmd.data;
        n_item.is_go = (i_cmd.data.kind == K_WRITE) && (i_cmd.data.reg_index == R_CS)
                       && i_cmd.data.write_data[0];
        n_item.is_done = (i_cmd.data.kind == K_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ sv/dccs_back.sv @@
// Back end: register file and command execution, one item per cycle while the result output is not stalled.
module dccs_back import dccs_pkg::*; #(
    parameter int LAST_CYLINDER = 202,
    parameter int LAST_SECTOR   = 11,
    parameter int SECTOR_WORDS  = 256,
    parameter int UNIT_COUNT    = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_ready,
    dccs_res_if.source o_res
);
    logic [15:0] r_cs, n_cs;
    logic [15:0] r_er, n_er;
    logic [3:0]  r_sec, n_sec;
    logic        r_surf, n_surf;
    logic [7:0]  r_cyl, n_cyl;
    logic [2:0]  r_unit, n_unit;
    logic [2:0]  r_iunit, n_iunit;
    logic [15:0] r_wc, n_wc;
    logic [17:0] r_ba, n_ba;
    logic [15:0] r_db, n_db;
    logic [12:0] r_us [8];
    logic [7:0]  r_ac, n_ac;
    logic        r_ov;
    t_res        r_res, n_res;
    logic        fire, us_we;
    logic [2:0]  us_idx;

    assign o_q_ready = !r_ov || o_res.ready;
    assign fire = i_q_valid && o_q_ready;
    assign o_res.valid = r_ov;
    assign o_res.data = r_res;

    always_comb begin
        t_cmd c;
        logic [2:0] fn;
        logic fmt, bad, stop, irq;
        logic [12:0] ss;
        logic [16:0] left;
        logic [8:0] chunk;
        logic [4:0] s1;
        logic do_issue;
        c = i_q_item.cmd;
        n_cs = r_cs; n_er = r_er; n_sec = r_sec; n_surf = r_surf; n_cyl = r_cyl;
        n_unit = r_unit; n_iunit = r_iunit; n_wc = r_wc; n_ba = r_ba; n_db = r_db;
        n_ac = r_ac; n_res = '0; us_we = 1'b0; us_idx = c.drive_unit;
        irq = 1'b0; stop = 1'b0; do_issue = 1'b0; bad = 1'b0; fmt = 1'b0;
        ss = (32'(r_unit) < UNIT_COUNT) ? r_us[r_unit] : 13'd0;
        fn = r_ac[3:1];
        left = 17'h10000 - {1'b0, r_wc};
        chunk = (left < 17'(SECTOR_WORDS)) ? left[8:0] : 9'(SECTOR_WORDS);
        if (fn == FN_READ && r_ac[4]) chunk = 9'd1;
        s1 = {1'b0, r_sec} + 5'd1;
        case (c.kind)
            K_WRITE: begin
                if (c.reg_index == R_CS) begin
                    n_cs = (r_cs & ~CS_WRITABLE) | (c.write_data & CS_WRITABLE);
                    n_ba[17:16] = c.write_data[5:4];
                    if (i_q_item.is_go) begin
                        fn = n_cs[3:1];
                        fmt = n_cs[10];
                        if (fmt && fn != FN_READ && fn != FN_WRITE && fn != FN_RESET) begin
                            n_er = n_er | ER_PGE;
                            n_cs = (n_cs | CS_HE | CS_ERR) & ~CS_GO;
                        end else if (fn == FN_RESET) begin
                            n_cs = CS_RDY; n_er = '0; n_sec = '0; n_surf = 1'b0;
                            n_cyl = '0; n_unit = '0; n_iunit = '0; n_wc = '0;
                            n_ba = '0; n_db = '0; n_ac = '0;
                        end else if (fn == FN_WLOCK) begin
                            n_cs = n_cs & ~CS_GO & ~CS_SCP;
                            n_res.write_protect_set = 1'b1;
                            n_res.request_disk_address = {r_unit, r_cyl, r_surf, r_sec};
                            irq = n_cs[6];
                        end else if (!ss[7] || (fn != FN_DRESET && (|(ss &
                                     (DS_SIN | DS_DRU | DS_DPL))))) begin
                            n_er = n_er | ((fn != FN_DRESET && !(ss[7] &&
                                   !(|(ss & (DS_SIN | DS_DRU | DS_DPL))))) ? ER_DRE : ER_NXD);
                            n_cs = (n_cs | CS_HE | CS_ERR) & ~CS_GO & ~CS_SCP;
                            irq = n_cs[6];
                        end else begin
                            n_cs = n_cs & ~(CS_GO | CS_RDY | CS_SCP);
                            n_ac = {1'b1, 2'b00, fmt, fn, 1'b0};
                            n_ac[5] = n_cs[11];
                            if (fn == FN_SEEK) begin
                                bad = (32'(r_sec) > LAST_SECTOR) || (32'(r_cyl) > LAST_CYLINDER)
                                      || !ss[7];
                                if (32'(r_sec) > LAST_SECTOR) n_er = n_er | ER_NXS;
                                if (32'(r_cyl) > LAST_CYLINDER) n_er = n_er | ER_NXC;
                                if (!ss[7]) n_er = n_er | ER_NXD;
                                n_cs = n_cs | CS_RDY;
                                n_ac = '0;
                                if (bad) n_cs = n_cs | CS_HE | CS_ERR;
                                else begin
                                    n_iunit = '0;
                                    n_res.seek_start = 1'b1;
                                    n_res.request_disk_address = {r_unit, r_cyl, r_surf, r_sec};
                                    irq = n_cs[6];
                                end
                            end else if (fn == FN_DRESET) begin
                                n_res.drive_reset_start = 1'b1;
                                n_res.request_disk_address = {r_unit, r_cyl, r_surf, r_sec};
                                n_cs = n_cs | CS_RDY;
                                n_ac = '0;
                                irq = n_cs[6];
                            end else begin
                                do_issue = 1'b1;
                                // chunk for the new command
                                left = 17'h10000 - {1'b0, r_wc};
                                chunk = (left < 17'(SECTOR_WORDS)) ? left[8:0]
                                        : 9'(SECTOR_WORDS);
                                if (fn == FN_READ && fmt) chunk = 9'd1;
                            end
                        end
                    end else if (n_cs[7] && n_cs[6]) begin
                        irq = 1'b1;
                    end
                end else if (r_cs[7] && c.reg_index == R_WC) begin
                    n_wc = c.write_data;
                end else if (r_cs[7] && c.reg_index == R_BA) begin
                    n_ba[15:0] = c.write_data;
                end else if (r_cs[7] && c.reg_index == R_DA) begin
                    n_sec = c.write_data[3:0];
                    n_surf = c.write_data[4];
                    n_cyl = c.write_data[12:5];
                    n_unit = c.write_data[15:13];
                end
            end
            K_READ: begin
                case (c.reg_index)
                    R_DS: begin
                        n_res.read_data = {r_iunit, ss & DS_MASK};
                        if ((ss[3:0]) == r_sec) n_res.read_data[4] = 1'b1;
                    end
                    R_ER: n_res.read_data = r_er;
                    R_CS: n_res.read_data = r_cs;
                    R_WC: n_res.read_data = r_wc;
                    R_BA: n_res.read_data = r_ba[15:0];
                    R_DA: n_res.read_data = {r_unit, r_cyl, r_surf, r_sec};
                    R_DB: n_res.read_data = r_db;
                    default: n_res.read_data = '0;
                endcase
            end
            K_DONE: begin
                if (i_q_item.is_done && r_ac[7] && (fn == FN_WRITE || fn == FN_READ
                                || fn == FN_WCHECK || fn == FN_RCHECK)) begin
                    if (fn != FN_RCHECK) begin
                        if (c.dma_timeout) begin
                            n_er = n_er | ER_NXM;
                            n_cs = n_cs | CS_HE | CS_ERR;
                            stop = 1'b1;
                        end else if (fn == FN_WCHECK) begin
                            if (c.compare_mismatch) begin
                                n_er = n_er | ER_WCE;
                                n_cs = n_cs | CS_ERR;
                                stop = r_cs[8];
                            end
                        end else if (fn == FN_READ) begin
                            n_db = c.last_word;
                        end
                    end
                    n_wc = r_wc + 16'(chunk);
                    if (!r_ac[5]) n_ba = r_ba + {8'd0, chunk, 1'b0};
                    if (32'(s1) > LAST_SECTOR) begin
                        n_sec = '0;
                        n_surf = ~r_surf;
                        if (r_surf) n_cyl = r_cyl + 8'd1;
                    end else begin
                        n_sec = s1[3:0];
                    end
                    if (stop || n_wc == 16'd0) begin
                        n_cs = n_cs | CS_RDY;
                        n_ac = '0;
                        irq = n_cs[6];
                    end else begin
                        do_issue = 1'b1;
                        left = 17'h10000 - {1'b0, n_wc};
                        chunk = (left < 17'(SECTOR_WORDS)) ? left[8:0] : 9'(SECTOR_WORDS);
                        if (fn == FN_READ && r_ac[4]) chunk = 9'd1;
                    end
                end
            end
            default: begin
                if (32'(c.drive_unit) < UNIT_COUNT) begin
                    us_we = 1'b1;
                    if (c.search_complete && r_cs[6]) begin
                        n_cs = n_cs | CS_SCP;
                        n_iunit = c.drive_unit;
                        irq = 1'b1;
                    end
                end
            end
        endcase
        if (do_issue) begin
            fn = n_ac[3:1];
            bad = (32'(n_sec) > LAST_SECTOR) || (32'(n_cyl) > LAST_CYLINDER) || !ss[7];
            if (32'(n_sec) > LAST_SECTOR) n_er = n_er | ER_NXS;
            if (32'(n_cyl) > LAST_CYLINDER) n_er = n_er | ER_NXC | ER_OVR;
            if (!ss[7]) n_er = n_er | ER_NXD;
            if (bad) begin
                n_cs = n_cs | CS_HE | CS_ERR | CS_RDY;
                n_ac = '0;
                irq = n_cs[6];
            end else begin
                n_res.sector_request = 1'b1;
                if (fn == FN_WRITE) n_res.transfer_direction = DIR_WRITE;
                else if (fn == FN_WCHECK) n_res.transfer_direction = DIR_WCHECK;
                else if (fn == FN_RCHECK || n_ac[4]) n_res.transfer_direction = DIR_HEADER;
                else n_res.transfer_direction = DIR_READ;
                n_res.request_disk_address = {r_unit, n_cyl, n_surf, n_sec};
                n_res.request_bus_address = n_ba;
                n_res.request_word_count = chunk;
            end
        end
        n_cs[5:4] = n_ba[17:16];
        n_res.interrupt = irq;
        n_res.ready_res = n_cs[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_us[k] <= '0;
        end else if (fire && us_we) begin
            r_us[us_idx] <= i_q_item.cmd.drive_status & DS_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= CS_RDY; r_er <= '0; r_sec <= '0; r_surf <= 1'b0; r_cyl <= '0;
            r_unit <= '0; r_iunit <= '0; r_wc <= '0; r_ba <= '0; r_db <= '0;
            r_ac <= '0; r_ov <= 1'b0;
        end else begin
            if (fire) begin
                r_cs <= n_cs; r_er <= n_er; r_sec <= n_sec; r_surf <= n_surf;
                r_cyl <= n_cyl; r_unit <= n_unit; r_iunit <= n_iunit; r_wc <= n_wc;
                r_ba <= n_ba; r_db <= n_db; r_ac <= n_ac;
            end
            if (fire) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end
endmodule

@@ sv/disk_controller_command_sequencer.sv @@
// Disk controller command sequencer: queues items and executes them in order.
// Path: an accepted input is held in the front-end queue, then in the output register; stalls add to the delay.
// Throughput: one item per cycle while the result output is not stalled.
// A two-entry queue and one output register decouple the two sides.
// Synchronous active-low reset: CS reads 0x0080, all drives absent.
module disk_controller_command_sequencer import dccs_pkg::*; #(
    parameter int LAST_CYLINDER = 202,
    parameter int LAST_SECTOR   = 11,
    parameter int SECTOR_WORDS  = 256,
    parameter int UNIT_COUNT    = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    dccs_cmd_if.sink i_cmd,
    dccs_res_if.source o_res
);
`include "assert_macros.svh"
    logic  q_valid, q_ready;
    t_item q_item;

    dccs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_ready(q_ready)
    );

    dccs_back #(
        .LAST_CYLINDER(LAST_CYLINDER), .LAST_SECTOR(LAST_SECTOR),
        .SECTOR_WORDS(SECTOR_WORDS), .UNIT_COUNT(UNIT_COUNT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_ready(q_ready), .o_res(o_res)
    );

    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.data), "result changed while stalled")
    `ASSERT_CLK(a_req_count, i_clk, i_rst_n, !(o_res.valid && o_res.data.sector_request) || (o_res.data.request_word_count != 9'd0), "sector request with zero words")
    `ASSERT_CLK(a_one_action, i_clk, i_rst_n, !o_res.valid || $onehot0({o_res.data.sector_request, o_res.data.seek_start, o_res.data.drive_reset_start, o_res.data.write_protect_set}), "several drive actions at once")
endmodule
